### src/etc_pkg.sv
// Shared types, constants and register codes for the EEPROM transfer chunker.
package etc_pkg;

    localparam int ADDR_WIDTH_DEF        = 17;
    localparam int MAX_REQUEST_BYTES_DEF = 256;

    localparam int CNT_W       = 9;
    localparam int SLAVE_W     = 9;
    localparam int LOCAL_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int LOG2_W      = 4;
    localparam int TOTAL_W     = 18;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int RESULT_CAP  = 33;
    localparam int NUM_W       = 6;

    localparam logic [CNT_W-1:0]   LIM_MIN      = 9'd8;
    localparam logic [CNT_W-1:0]   LIM_MAX      = 9'd256;
    localparam logic [LOG2_W-1:0]  PAGE_LOG2_MIN = 4'd3;
    localparam logic [LOG2_W-1:0]  PAGE_LOG2_MAX = 4'd8;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET  = 18'd131072;
    localparam logic [LOG2_W-1:0]  PAGE_RESET   = 4'd7;
    localparam logic [CNT_W-1:0]   WR_MAX_RESET = 9'd128;
    localparam logic [CNT_W-1:0]   IO_LIM_RESET = 9'd128;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ADDR16_MODE      = 3'd0,
        CFG_NO_READ_ROLLOVER = 3'd1,
        CFG_READ_ONLY        = 3'd2,
        CFG_TOTAL_BYTES      = 3'd3,
        CFG_PAGE_SIZE_LOG2   = 3'd4,
        CFG_WRITE_MAX        = 3'd5,
        CFG_IO_LIMIT         = 3'd6
    } etc_cfg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_XFER       = 2'd0,
        STS_EMPTY_READ = 2'd1,
        STS_RANGE      = 2'd2,
        STS_REFUSED    = 2'd3
    } etc_status_t;

    // limits as seen by the chunk unit, already saturated
    typedef struct packed {
        logic               addr16;
        logic               no_rollover;
        logic [CNT_W-1:0]   rd_lim;
        logic [CNT_W-1:0]   wr_lim;
        logic [LOG2_W-1:0]  page_log2;
    } etc_lim_t;

endpackage

### src/etc_chunk_unit.sv
// Chunk size unit: bytes of the next transfer from the cursor and the limits.
module etc_chunk_unit (
    input  etc_pkg::etc_lim_t                 lim,
    input  logic                              is_write,
    input  logic [etc_pkg::LOCAL_W-1:0]       local_addr,
    input  logic [etc_pkg::CNT_W-1:0]         bytes_left,
    output logic [etc_pkg::CNT_W-1:0]         chunk
);
    import etc_pkg::*;

    logic [CNT_W-1:0]   cap;
    logic [CNT_W-1:0]   c1;
    logic [CNT_W-1:0]   page_mask;
    logic [CNT_W-1:0]   page_room;
    logic [LOCAL_W:0]   slave_room;

    always_comb begin
        cap        = is_write ? lim.wr_lim : lim.rd_lim;
        c1         = (bytes_left < cap) ? bytes_left : cap;
        page_mask  = (CNT_W'(1) << lim.page_log2) - CNT_W'(1);
        page_room  = (page_mask + CNT_W'(1)) - {1'b0, local_addr[7:0] & page_mask[7:0]};
        slave_room = lim.addr16 ? ((LOCAL_W+1)'(1) << 16) - {1'b0, local_addr}
                                : ((LOCAL_W+1)'(1) << 8) - {9'b0, local_addr[7:0]};
        chunk      = c1;
        if (is_write) begin
            if (c1 > page_room) begin
                chunk = page_room;
            end
        end else if (lim.no_rollover && ({8'b0, c1} > slave_room)) begin
            chunk = slave_room[CNT_W-1:0];
        end
    end

endmodule

### src/eeprom_transfer_chunker.sv
// Top level of the EEPROM transfer chunker: request check and transfer sequencer.
// Splits a read or write request into device transfers, one result per cycle while
// the output is not stalled. A request is accepted, then given a range and permission
// check, then emits one transfer result per chunk, at most 33 for a 256-byte request;
// a refused, out-of-range or empty request gives a single status result instead.
// The single chunk-size unit is shared by every transfer of a request, and the
// input is not ready again until the last result is in the output register.
module eeprom_transfer_chunker #(
    parameter int ADDR_WIDTH        = etc_pkg::ADDR_WIDTH_DEF,
    parameter int MAX_REQUEST_BYTES = etc_pkg::MAX_REQUEST_BYTES_DEF,
    localparam int IN_DATA_W        = ((ADDR_WIDTH + etc_pkg::CNT_W + 7) / 8) * 8,
    localparam int OUT_DATA_W       = ((etc_pkg::SLAVE_W + etc_pkg::LOCAL_W
                                        + etc_pkg::CNT_W + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [IN_DATA_W-1:0]                s_axis_tdata,  // start_offset, byte_count
    input  logic [0:0]                          s_axis_tuser,  // func
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [OUT_DATA_W-1:0]               m_axis_tdata,  // slave_index, chunk_address, chunk_bytes
    output logic [etc_pkg::STATUS_W-1:0]        m_axis_tuser,  // status
    output logic                                m_axis_tlast,
    input  logic                                cfg_wr_en,
    input  logic [etc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [etc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import etc_pkg::*;

    localparam int SUM_W = (ADDR_WIDTH + 1 > TOTAL_W) ? ADDR_WIDTH + 1 : TOTAL_W;
    localparam int XW    = ADDR_WIDTH + LOCAL_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN
    } state_t;

    // configuration
    logic               addr16_reg;
    logic               no_rollover_reg;
    logic               read_only_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [LOG2_W-1:0]  page_log2_reg;
    logic [CNT_W-1:0]   wr_max_reg;
    logic [CNT_W-1:0]   io_lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr16_reg      <= 1'b1;
            no_rollover_reg <= 1'b0;
            read_only_reg   <= 1'b0;
            total_reg       <= TOTAL_RESET;
            page_log2_reg   <= PAGE_RESET;
            wr_max_reg      <= WR_MAX_RESET;
            io_lim_reg      <= IO_LIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (etc_cfg_index_t'(cfg_index))
                CFG_ADDR16_MODE:      addr16_reg      <= cfg_wdata[0];
                CFG_NO_READ_ROLLOVER: no_rollover_reg <= cfg_wdata[0];
                CFG_READ_ONLY:        read_only_reg   <= cfg_wdata[0];
                CFG_TOTAL_BYTES:      total_reg       <= cfg_wdata[TOTAL_W-1:0];
                CFG_PAGE_SIZE_LOG2:   page_log2_reg   <= cfg_wdata[LOG2_W-1:0];
                CFG_WRITE_MAX:        wr_max_reg      <= cfg_wdata[CNT_W-1:0];
                CFG_IO_LIMIT:         io_lim_reg      <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    etc_lim_t lim;

    always_comb begin
        lim.addr16      = addr16_reg;
        lim.no_rollover = no_rollover_reg;
        lim.rd_lim      = (io_lim_reg < LIM_MIN) ? LIM_MIN
                        : ((io_lim_reg > LIM_MAX) ? LIM_MAX : io_lim_reg);
        lim.wr_lim      = (wr_max_reg < LIM_MIN) ? LIM_MIN
                        : ((wr_max_reg > LIM_MAX) ? LIM_MAX : wr_max_reg);
        lim.page_log2   = (page_log2_reg < PAGE_LOG2_MIN) ? PAGE_LOG2_MIN
                        : ((page_log2_reg > PAGE_LOG2_MAX) ? PAGE_LOG2_MAX : page_log2_reg);
    end

    // sequencer
    state_t                 state_reg, state_next;
    logic                   wr_reg, wr_next;
    logic [ADDR_WIDTH-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]       left_reg, left_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic                   ovalid_reg, ovalid_next;
    logic [SLAVE_W-1:0]     oslave_reg, oslave_next;
    logic [LOCAL_W-1:0]     oaddr_reg, oaddr_next;
    logic [CNT_W-1:0]       obytes_reg, obytes_next;
    logic [STATUS_W-1:0]    ostatus_reg, ostatus_next;
    logic                   olast_reg, olast_next;

    logic                   in_fire;
    logic                   out_free;
    logic [SUM_W-1:0]       space;
    logic [SUM_W-1:0]       total_x;
    logic [SUM_W-1:0]       size;
    logic [SUM_W-1:0]       req_end;
    logic [XW-1:0]          cur_x;
    logic [XW-1:0]          slave_sh;
    logic [LOCAL_W-1:0]     local_addr;
    logic [CNT_W-1:0]       chunk;
    logic [CNT_W-1:0]       left_after;
    logic                   final_xfer;

    etc_chunk_unit u_chunk (
        .lim        (lim),
        .is_write   (wr_reg),
        .local_addr (local_addr),
        .bytes_left (left_reg),
        .chunk      (chunk)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ovalid_reg || m_axis_tready;

    always_comb begin
        space      = SUM_W'(1) << ADDR_WIDTH;
        total_x    = SUM_W'(total_reg);
        size       = (total_x > space) ? space : total_x;
        req_end    = SUM_W'(cursor_reg) + SUM_W'(left_reg);
        cur_x      = XW'(cursor_reg);
        slave_sh   = addr16_reg ? (cur_x >> 16) : (cur_x >> 8);
        local_addr = addr16_reg ? cur_x[LOCAL_W-1:0] : {8'b0, cur_x[7:0]};
        left_after = left_reg - chunk;
        final_xfer = (left_after == '0) || (num_reg == NUM_W'(RESULT_CAP - 1));

        state_next   = state_reg;
        wr_next      = wr_reg;
        cursor_next  = cursor_reg;
        left_next    = left_reg;
        num_next     = num_reg;
        ovalid_next  = ovalid_reg && !m_axis_tready;
        oslave_next  = oslave_reg;
        oaddr_next   = oaddr_reg;
        obytes_next  = obytes_reg;
        ostatus_next = ostatus_reg;
        olast_next   = olast_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    wr_next     = s_axis_tuser[0];
                    cursor_next = s_axis_tdata[ADDR_WIDTH-1:0];
                    left_next   = s_axis_tdata[ADDR_WIDTH +: CNT_W];
                    num_next    = '0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (out_free) begin
                    oslave_next = '0;
                    oaddr_next  = '0;
                    obytes_next = '0;
                    olast_next  = 1'b1;
                    state_next  = ST_IDLE;
                    if (left_reg == '0) begin
                        ovalid_next  = 1'b1;
                        ostatus_next = wr_reg ? STS_RANGE : STS_EMPTY_READ;
                    end else if ((left_reg > CNT_W'(MAX_REQUEST_BYTES)) || (req_end > size)) begin
                        ovalid_next  = 1'b1;
                        ostatus_next = STS_RANGE;
                    end else if (wr_reg && read_only_reg) begin
                        ovalid_next  = 1'b1;
                        ostatus_next = STS_REFUSED;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    ovalid_next  = 1'b1;
                    oslave_next  = slave_sh[SLAVE_W-1:0];
                    oaddr_next   = local_addr;
                    obytes_next  = chunk;
                    ostatus_next = STS_XFER;
                    olast_next   = final_xfer;
                    cursor_next  = ADDR_WIDTH'(cursor_reg + ADDR_WIDTH'(chunk));
                    left_next    = left_after;
                    num_next     = num_reg + NUM_W'(1);
                    if (final_xfer) begin
                        left_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            wr_reg     <= 1'b0;
            cursor_reg <= '0;
            left_reg   <= '0;
            num_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            wr_reg     <= wr_next;
            cursor_reg <= cursor_next;
            left_reg   <= left_next;
            num_reg    <= num_next;
            ovalid_reg <= ovalid_next;
        end
        oslave_reg  <= oslave_next;
        oaddr_reg   <= oaddr_next;
        obytes_reg  <= obytes_next;
        ostatus_reg <= ostatus_next;
        olast_reg   <= olast_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({obytes_reg, oaddr_reg, oslave_reg});
    assign m_axis_tuser  = ostatus_reg;
    assign m_axis_tlast  = olast_reg;

    // a running request always has bytes outstanding
    a_run_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> left_reg != '0)
        else $error("transfer sequencer running with no bytes left");

    // every transfer result moves at least one byte
    a_xfer_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        ovalid_reg && ostatus_reg == STS_XFER |-> obytes_reg != '0)
        else $error("empty transfer emitted");

    // a status-only result closes its request
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ovalid_reg && ostatus_reg != STS_XFER |-> olast_reg && obytes_reg == '0)
        else $error("status result not marked last");

endmodule

### verif/eeprom_transfer_chunker_tb.sv
// Self-checking bench for the EEPROM transfer chunker: random and directed requests, split predicted.
module eeprom_transfer_chunker_tb;
    import etc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RAND_PER_PHASE = 40;

    typedef struct {
        logic        wr;
        logic [16:0] start;
        logic [8:0]  count;
    } request_t;

    typedef struct {
        logic [SLAVE_W-1:0] slave;
        logic [LOCAL_W-1:0] addr;
        logic [CNT_W-1:0]   bytes;
        etc_status_t        status;
        logic               last;
    } transfer_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_valid = 1'b0;
    logic                   s_axis_tready;
    request_t               cur_req = '{1'b0, 17'd0, 9'd0};
    logic                   m_axis_tvalid;
    logic                   m_ready = 1'b0;
    logic [39:0]            m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // register copies, masked to their widths
    logic        r_addr16;
    logic        r_no_rollover;
    logic        r_read_only;
    logic [17:0] r_total;
    logic [3:0]  r_page_log2;
    logic [8:0]  r_write_max;
    logic [8:0]  r_io_limit;

    request_t  request_q[$];
    transfer_t due_transfers[$];
    int        errors       = 0;
    int        stall_cycles = 0;
    int        s_idle_pct   = 0;
    int        m_stall_pct  = 0;

    eeprom_transfer_chunker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  ({6'd0, cur_req.count, cur_req.start}),  // start_offset, byte_count
        .s_axis_tuser  (cur_req.wr),                            // func
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),  // slave_index, chunk_address, chunk_bytes
        .m_axis_tuser  (m_axis_tuser),  // status
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int unsigned device_size();
        return r_total > 18'd131072 ? 32'd131072 : 32'(r_total);
    endfunction

    task automatic push_status(input etc_status_t st);
        transfer_t t;
        t = '{'0, '0, '0, st, 1'b1};
        due_transfers.push_back(t);
    endtask

    task automatic split_request(input request_t rq);
        int unsigned size, rd_lim, wr_lim, page, bits, lmask;
        int unsigned cur, left, chunk, loc, page_end, room;
        int          n;
        transfer_t   t;
        size   = device_size();
        rd_lim = clamp_u(32'(r_io_limit), 8, 256);
        wr_lim = clamp_u(32'(r_write_max), 8, 256);
        page   = 1 << clamp_u(32'(r_page_log2), 3, 8);
        bits   = r_addr16 ? 16 : 8;
        lmask  = r_addr16 ? 32'hffff : 32'hff;
        n      = 0;
        if (rq.count == 0) begin
            push_status(rq.wr ? STS_RANGE : STS_EMPTY_READ);
        end else if (rq.count > 256 || rq.start + rq.count > size) begin
            push_status(STS_RANGE);
        end else if (rq.wr && r_read_only) begin
            push_status(STS_REFUSED);
        end else begin
            cur  = 32'(rq.start);
            left = 32'(rq.count);
            while (left != 0 && n < RESULT_CAP) begin
                loc   = cur & lmask;
                chunk = left;
                if (rq.wr) begin
                    if (chunk > wr_lim) chunk = wr_lim;
                    page_end = (loc / page + 1) * page;
                    if (loc + chunk > page_end) chunk = page_end - loc;
                end else begin
                    if (r_no_rollover) begin
                        room = (1 << bits) - loc;
                        if (chunk > room) chunk = room;
                    end
                    if (chunk > rd_lim) chunk = rd_lim;
                end
                left -= chunk;
                t.slave  = SLAVE_W'(cur >> bits);
                t.addr   = LOCAL_W'(loc);
                t.bytes  = CNT_W'(chunk);
                t.status = STS_XFER;
                t.last   = (left == 0 || n == RESULT_CAP - 1);
                cur += chunk;
                due_transfers.push_back(t);
                n++;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_transfer();
        transfer_t t;
        if (due_transfers.size() == 0) begin
            report_mismatch($sformatf("unexpected item data=%h status=%0d last=%0b",
                                      m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
            t = due_transfers.pop_front();
            if (m_axis_tdata[8:0] !== t.slave)
                report_mismatch($sformatf("slave_index %0d, want %0d", m_axis_tdata[8:0], t.slave));
            if (m_axis_tdata[24:9] !== t.addr)
                report_mismatch($sformatf("chunk_address %h, want %h", m_axis_tdata[24:9], t.addr));
            if (m_axis_tdata[33:25] !== t.bytes)
                report_mismatch($sformatf("chunk_bytes %0d, want %0d",
                                          m_axis_tdata[33:25], t.bytes));
            if (m_axis_tuser !== t.status)
                report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, t.status));
            if (m_axis_tlast !== t.last)
                report_mismatch($sformatf("last %0b, want %0b", m_axis_tlast, t.last));
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_axis_tready) split_request(cur_req);
            if (!s_valid || s_axis_tready) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
                    cur_req <= request_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_ready) check_transfer();
        m_ready <= ($urandom_range(0, 99) >= m_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_cfg(input etc_cfg_index_t idx, input logic [17:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ADDR16_MODE:      r_addr16      = val[0];
            CFG_NO_READ_ROLLOVER: r_no_rollover = val[0];
            CFG_READ_ONLY:        r_read_only   = val[0];
            CFG_TOTAL_BYTES:      r_total       = val[17:0];
            CFG_PAGE_SIZE_LOG2:   r_page_log2   = val[3:0];
            CFG_WRITE_MAX:        r_write_max   = val[8:0];
            CFG_IO_LIMIT:         r_io_limit    = val[8:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_limits(input logic a16, input logic nro, input logic ro,
                              input logic [17:0] total, input logic [3:0] plog,
                              input logic [8:0] wmax, input logic [8:0] iolim);
        write_cfg(CFG_ADDR16_MODE, 18'(a16));
        write_cfg(CFG_NO_READ_ROLLOVER, 18'(nro));
        write_cfg(CFG_READ_ONLY, 18'(ro));
        write_cfg(CFG_TOTAL_BYTES, total);
        write_cfg(CFG_PAGE_SIZE_LOG2, 18'(plog));
        write_cfg(CFG_WRITE_MAX, 18'(wmax));
        write_cfg(CFG_IO_LIMIT, 18'(iolim));
    endtask

    task automatic add_request(input logic wr, input logic [16:0] start, input logic [8:0] count);
        request_t rq;
        rq = '{wr, start, count};
        request_q.push_back(rq);
    endtask

    task automatic add_random_request();
        int unsigned size, room;
        request_t    rq;
        size = device_size();
        if (size == 0 || $urandom_range(0, 99) < 15) begin
            rq.wr    = 1'($urandom_range(0, 1));
            rq.start = 17'($urandom_range(0, 131071));
            rq.count = 9'($urandom_range(0, 511));
        end else begin
            rq.wr    = 1'($urandom_range(0, 1));
            rq.start = 17'($urandom_range(0, size - 1));
            room     = size - 32'(rq.start);
            if (room > 256) room = 256;
            rq.count = 9'(($urandom_range(0, 3) == 0) ? room : $urandom_range(1, room));
        end
        request_q.push_back(rq);
    endtask

    // block is idle once every request is taken and every transfer seen
    task automatic drain();
        do @(negedge aclk);
        while (request_q.size() != 0 || s_valid || due_transfers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        r_addr16      = 1'b1;
        r_no_rollover = 1'b0;
        r_read_only   = 1'b0;
        r_total       = TOTAL_RESET;
        r_page_log2   = PAGE_RESET;
        r_write_max   = WR_MAX_RESET;
        r_io_limit    = IO_LIM_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limits
        add_request(1'b0, 17'd0, 9'd0);
        add_request(1'b1, 17'd0, 9'd0);
        add_request(1'b0, 17'd0, 9'd256);
        add_request(1'b1, 17'd0, 9'd256);
        add_request(1'b1, 17'd5, 9'd256);
        add_request(1'b0, 17'd131071, 9'd1);
        add_request(1'b0, 17'd131071, 9'd2);
        add_request(1'b1, 17'd131000, 9'd256);
        add_request(1'b0, 17'd0, 9'd257);
        add_request(1'b0, 17'd100, 9'd511);
        add_request(1'b0, 17'd65500, 9'd100);
        drain();

        // 8-bit addressing, smallest pages and limits
        set_limits(1'b0, 1'b1, 1'b0, 18'd131072, 4'd3, 9'd8, 9'd8);
        add_request(1'b0, 17'd250, 9'd20);
        add_request(1'b1, 17'd3, 9'd256);
        add_request(1'b0, 17'd130816, 9'd256);
        add_request(1'b1, 17'd131064, 9'd8);
        drain();

        // read-only, one-byte device, limits below their floor and above their ceiling
        set_limits(1'b1, 1'b0, 1'b1, 18'd1, 4'd0, 9'd0, 9'd511);
        add_request(1'b1, 17'd0, 9'd1);
        add_request(1'b1, 17'd0, 9'd0);
        add_request(1'b1, 17'd0, 9'd2);
        add_request(1'b0, 17'd0, 9'd1);
        add_request(1'b0, 17'd0, 9'd0);
        drain();

        // oversized device, largest page and limits
        set_limits(1'b1, 1'b1, 1'b0, 18'h3ffff, 4'd15, 9'd511, 9'd256);
        add_request(1'b1, 17'd131071, 9'd1);
        add_request(1'b0, 17'd65530, 9'd20);
        add_request(1'b1, 17'd0, 9'd256);
        add_request(1'b0, 17'd1, 9'd256);
        drain();

        for (int mode = 0; mode < 4; mode++) begin
            for (int rep = 0; rep < 2; rep++) begin
                set_limits(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 3) == 0,
                           ($urandom_range(0, 2) == 0) ? 18'd131072
                                                       : 18'($urandom_range(0, 262143)),
                           4'($urandom_range(0, 15)), 9'($urandom_range(0, 511)),
                           9'($urandom_range(0, 511)));
                case (mode)
                    0: begin s_idle_pct = 0;  m_stall_pct = 0;  end
                    1: begin s_idle_pct = 69; m_stall_pct = 0;  end
                    2: begin s_idle_pct = 0;  m_stall_pct = 69; end
                    default: begin s_idle_pct = 36; m_stall_pct = 36; end
                endcase
                repeat (RAND_PER_PHASE) add_random_request();
                drain();
            end
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
